FILE: rtl/core/clna_pkg.sv
// Shared types, codes and defaults for the contiguous line number allocator.
`default_nettype none

package clna_pkg;

   // Default map size
   localparam int NUM_LINES_DEF = 256;

   // Field widths fixed by the request and response formats
   localparam int ACT_W  = 2;
   localparam int LINE_W = 8;
   localparam int LEN_W  = 9;
   localparam int STS_W  = 3;
   localparam int OUT_W  = 9;
   localparam int LB_W   = 9;

   // Request actions
   localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_MARK  = 2'd2;
   localparam logic [ACT_W-1:0] ACT_FIND  = 2'd3;

   // Response status codes
   localparam logic [STS_W-1:0] STS_OK      = 3'd0;
   localparam logic [STS_W-1:0] STS_INVALID = 3'd1;
   localparam logic [STS_W-1:0] STS_USED    = 3'd2;
   localparam logic [STS_W-1:0] STS_NOSPACE = 3'd3;
   localparam logic [STS_W-1:0] STS_RANGE   = 3'd4;

   // One request beat
   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic              want_specific;
      logic [LINE_W-1:0] requested_line;
      logic [LINE_W-1:0] start_point;
      logic [LEN_W-1:0]  run_length;
   } clna_req_type;

   // One response beat
   typedef struct packed {
      logic [STS_W-1:0] status;
      logic [OUT_W-1:0] line_number;
   } clna_rsp_type;

   // Bitmap write control
   typedef struct packed {
      logic en;
      logic data;
   } clna_wr_type;

endpackage

`default_nettype wire

FILE: rtl/core/clna_map.sv
// Line usage bitmap: single-port write, registered read, clearing sweep after reset.
`default_nettype none

module clna_map
   import clna_pkg::*;
#(
   parameter int NUM_LINES = NUM_LINES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire clna_wr_type                  wr_ctl,
   input  wire logic [$clog2(NUM_LINES)-1:0] wr_addr,
   input  wire logic [$clog2(NUM_LINES)-1:0] rd_addr,
   output logic                              rd_bit_ff,
   output logic                              clr_busy
);

   localparam int AW = $clog2(NUM_LINES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_LINES - 1);

   logic          mem_ff [NUM_LINES];
   logic          clr_active_ff, clr_active_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // Clearing sweep, one entry a cycle
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   // Storage: sweep has priority over normal writes
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem_ff[clr_addr_ff] <= 1'b0;
      end else if (wr_ctl.en) begin
         mem_ff[wr_addr] <= wr_ctl.data;
      end
      rd_bit_ff <= mem_ff[rd_addr];
   end

   assign clr_busy = clr_active_ff;

endmodule

`default_nettype wire

FILE: rtl/core/contiguous_line_number_allocator.sv
// Contiguous line number allocator: top level with request sequencer and bitmap.
//
// Usage: drive req_data and raise start; the request is taken at a clock edge
// where start is high and busy is low. Each request gives exactly one response
// beat on rsp_data, marked by rsp_valid for one cycle; it cannot be stalled.
// csr_wr_en/csr_wr_data load the dynamic lower bound; the user is to write it only
// while the block is idle, and the block itself does not enforce this.
// The bitmap is scanned and updated one line per cycle through a single
// registered read port and a single write port:
//   - rejected requests, free of zero length: answered from the idle state
//   - mark: a single line is written; free of L lines: the L lines are cleared
//   - find next used from offset S: scan from S to a used line or the map end
//   - allocate of L lines: scan from the search start for a free run, then
//     its L lines are written (specific allocate scans only its L lines)
// One request is in flight at a time; for one not answered from the idle
// state, busy stays high until its response is issued.
// After reset the bitmap is swept clear and busy stays high until the sweep
// has ended; configuration writes are taken during the sweep.
`default_nettype none

module contiguous_line_number_allocator
   import clna_pkg::*;
#(
   parameter int NUM_LINES = NUM_LINES_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire clna_req_type    req_data,
   output logic                 rsp_valid,
   output clna_rsp_type         rsp_data,
   input  wire logic            csr_wr_en,
   input  wire logic [LB_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(NUM_LINES);
   localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;
   localparam logic [CW-1:0] LINES_W = CW'(NUM_LINES);
   localparam logic [CW-1:0] LAST_W  = CW'(NUM_LINES - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FIT,
      S_CHECK,
      S_FIND,
      S_WRITE
   } state_type;

   state_type        state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   clna_rsp_type     rsp_ff, rsp_in;
   logic [LB_W-1:0]  lower_bound_ff, lower_bound_in;
   logic [CW-1:0]    pos_ff, pos_in;
   logic [CW-1:0]    chk_pos_ff, chk_pos_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [LEN_W-1:0] run_ff, run_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [CW-1:0]    base_ff, base_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic             wdata_ff, wdata_in;
   logic [OUT_W-1:0] line_ff, line_in;

   clna_wr_type      wr_ctl;
   logic [AW-1:0]    rd_addr;
   logic             rd_bit;
   logic             clr_busy;

   // Request fields widened for range checks
   logic [CW-1:0]    req_w, start_w, len_w, lb_w, srch_w;
   logic [LEN_W-1:0] run_next;

   assign req_w   = CW'(req_data.requested_line);
   assign start_w = CW'(req_data.start_point);
   assign len_w   = CW'(req_data.run_length);
   assign lb_w    = CW'(lower_bound_ff);
   assign srch_w  = (start_w > lb_w) ? start_w : lb_w;
   assign run_next = run_ff + LEN_W'(1);

   // Bitmap
   clna_map #(
      .NUM_LINES (NUM_LINES)
   ) u_map (
      .clock     (clock),
      .reset     (reset),
      .wr_ctl    (wr_ctl),
      .wr_addr   (base_ff[AW-1:0]),
      .rd_addr   (rd_addr),
      .rd_bit_ff (rd_bit),
      .clr_busy  (clr_busy)
   );

   assign rd_addr     = (pos_ff < LINES_W) ? pos_ff[AW-1:0] : '0;
   assign wr_ctl.en   = (state_ff == S_WRITE);
   assign wr_ctl.data = wdata_ff;

   // Configuration register
   assign lower_bound_in = csr_wr_en ? csr_wr_data : lower_bound_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pos_in       = pos_ff;
      chk_pos_in   = chk_pos_ff;
      chk_vld_in   = chk_vld_ff;
      run_in       = run_ff;
      len_in       = len_ff;
      base_in      = base_ff;
      left_in      = left_ff;
      wdata_in     = wdata_ff;
      line_in      = line_ff;

      case (state_ff)
         S_CLEAR: begin
            if (!clr_busy) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               len_in     = req_data.run_length;
               run_in     = '0;
               chk_vld_in = 1'b0;
               line_in    = '0;
               rsp_in     = '{status: STS_OK, line_number: '0};
               case (req_data.action)
                  ACT_ALLOC: begin
                     if (req_data.run_length == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STS_INVALID;
                     end else if (req_data.want_specific) begin
                        if (req_data.start_point > req_data.requested_line) begin
                           rsp_valid_in  = 1'b1;
                           rsp_in.status = STS_INVALID;
                        end else if (req_w + len_w > LINES_W) begin
                           rsp_valid_in  = 1'b1;
                           rsp_in.status = STS_USED;
                        end else begin
                           pos_in   = req_w;
                           base_in  = req_w;
                           line_in  = OUT_W'(req_data.requested_line);
                           state_in = S_CHECK;
                        end
                     end else if (srch_w + len_w > LINES_W) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STS_NOSPACE;
                     end else begin
                        pos_in   = srch_w;
                        state_in = S_FIT;
                     end
                  end
                  ACT_FREE: begin
                     if (start_w >= LINES_W || start_w + len_w > LINES_W) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STS_RANGE;
                     end else if (req_data.run_length == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        base_in  = start_w;
                        left_in  = req_data.run_length;
                        wdata_in = 1'b0;
                        state_in = S_WRITE;
                     end
                  end
                  ACT_MARK: begin
                     if (req_w >= LINES_W) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STS_RANGE;
                     end else begin
                        base_in  = req_w;
                        left_in  = LEN_W'(1);
                        wdata_in = 1'b1;
                        state_in = S_WRITE;
                     end
                  end
                  default: begin
                     if (start_w >= LINES_W) begin
                        rsp_valid_in       = 1'b1;
                        rsp_in.line_number = LINES_W[OUT_W-1:0];
                     end else begin
                        pos_in   = start_w;
                        state_in = S_FIND;
                     end
                  end
               endcase
            end
         end

         // First fit: count free lines in a row from the search start
         S_FIT: begin
            pos_in     = pos_ff + CW'(1);
            chk_pos_in = pos_ff;
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               if (!rd_bit && run_next == len_ff) begin
                  base_in  = chk_pos_ff - CW'(len_ff) + CW'(1);
                  line_in  = OUT_W'(chk_pos_ff - CW'(len_ff) + CW'(1));
                  left_in  = len_ff;
                  wdata_in = 1'b1;
                  state_in = S_WRITE;
               end else if (chk_pos_ff == LAST_W) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STS_NOSPACE, line_number: '0};
                  state_in     = S_IDLE;
               end else begin
                  run_in = rd_bit ? '0 : run_next;
               end
            end
         end

         // Specific allocate: every line of the run must be free
         S_CHECK: begin
            pos_in     = pos_ff + CW'(1);
            chk_pos_in = pos_ff;
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               if (rd_bit) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STS_USED, line_number: '0};
                  state_in     = S_IDLE;
               end else if (run_next == len_ff) begin
                  left_in  = len_ff;
                  wdata_in = 1'b1;
                  state_in = S_WRITE;
               end else begin
                  run_in = run_next;
               end
            end
         end

         // Next used line at or after the offset
         S_FIND: begin
            pos_in     = pos_ff + CW'(1);
            chk_pos_in = pos_ff;
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               if (rd_bit) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STS_OK, line_number: chk_pos_ff[OUT_W-1:0]};
                  state_in     = S_IDLE;
               end else if (chk_pos_ff == LAST_W) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STS_OK, line_number: LINES_W[OUT_W-1:0]};
                  state_in     = S_IDLE;
               end
            end
         end

         // Write the run, one line a cycle
         S_WRITE: begin
            base_in = base_ff + CW'(1);
            left_in = left_ff - LEN_W'(1);
            if (left_ff == LEN_W'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STS_OK, line_number: line_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         rsp_valid_ff   <= 1'b0;
         lower_bound_ff <= '0;
         chk_vld_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         lower_bound_ff <= lower_bound_in;
         chk_vld_ff     <= chk_vld_in;
      end
      rsp_ff     <= rsp_in;
      pos_ff     <= pos_in;
      chk_pos_ff <= chk_pos_in;
      run_ff     <= run_in;
      len_ff     <= len_in;
      base_ff    <= base_in;
      left_ff    <= left_in;
      wdata_ff   <= wdata_in;
      line_ff    <= line_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // An accepted request either answers at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither answered nor in progress");

   // No request is taken while the bitmap sweep runs
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> busy)
      else $error("idle during bitmap clearing sweep");

   // Status codes stay within the defined set
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= STS_RANGE))
      else $error("undefined status code");

   // Failed requests report line zero
   a_fail_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STS_OK) |-> (rsp_data.line_number == '0))
      else $error("failed request with nonzero line");

   // A write run never starts or continues with nothing left
   a_write_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> (left_ff != '0))
      else $error("write run with zero lines left");
`endif

endmodule

`default_nettype wire
